@@ src/led_display_command_encoder_top_assert.svh @@
// ----------------------------------------------------------------------------
// led_display_command_encoder_top_assert.svh
// Assertion macros shared by the display command encoder RTL.
// ----------------------------------------------------------------------------
`ifndef LED_DISPLAY_COMMAND_ENCODER_TOP_ASSERT_SVH
`define LED_DISPLAY_COMMAND_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define LDCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define LDCE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LDCE_ASSERT(label, prop, msg)
`define LDCE_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ src/ldce_pkg.sv @@
// ----------------------------------------------------------------------------
// ldce_pkg
// Types, constants and the segment table of the display command encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ldce_pkg;

    // Opcode that opens every display command
    localparam logic [7:0] LED_SET_OPCODE_DEF = 8'd198;

    // Decimal point bit in a segment byte
    localparam logic [7:0] POINT_BIT = 8'h10;

    // Displayed range and reciprocals for division by constants
    localparam int unsigned DISPLAY_MOD   = 10000;
    localparam int unsigned RECIP_MOD     = 53687;   // floor(2^29 / 10000)
    localparam int unsigned RECIP_MOD_SH  = 29;
    localparam int unsigned RECIP_TEN     = 52429;   // ceil(2^19 / 10)
    localparam int unsigned RECIP_TEN_SH  = 19;

    // Number of display digits
    localparam int unsigned NUM_DIGITS = 4;
    localparam int unsigned DIG_IDX_W  = $clog2(NUM_DIGITS);

    // Width of a value below DISPLAY_MOD
    localparam int unsigned NUM_W = 14;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input word
    typedef struct packed {
        logic [15:0] value;
        logic [3:0]  digit_enable;
        logic [3:0]  point_enable;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_out_word;

    // Classified job: value already reduced below DISPLAY_MOD
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [3:0]       digit_enable;
        logic [3:0]       point_enable;
    } t_job;

    // Job handoff between two parts
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_link;

    // Segment pattern of one decimal digit
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'hE7;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'hCB;
            4'd3:    code = 8'h8F;
            4'd4:    code = 8'h2E;
            4'd5:    code = 8'hAD;
            4'd6:    code = 8'hED;
            4'd7:    code = 8'h86;
            4'd8:    code = 8'hEF;
            4'd9:    code = 8'hAF;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ src/ldce_front.sv @@
// ----------------------------------------------------------------------------
// ldce_front
// Accepts request words and reduces the value modulo 10000.
// ----------------------------------------------------------------------------
`default_nettype none

module ldce_front
    import ldce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_word  i_data,
    output t_job_link      o_link,
    input  wire logic      i_full
);

    logic             r_valid;
    logic [15:0]      r_value;
    logic [2:0]       r_quot;
    logic [3:0]       r_en;
    logic [3:0]       r_dp;

    logic [31:0]      w_prod;
    logic [16:0]      w_rem;
    logic [16:0]      w_rem_fix;
    logic             w_push;
    logic             w_take;

    // Estimate value / 10000; low by at most one
    assign w_prod = 32'(i_data.value) * 32'(RECIP_MOD);

    assign w_push = r_valid && !i_full;
    assign w_take = i_valid && !o_stall;
    assign o_stall = r_valid && i_full;

    // Hold the accepted word and its quotient estimate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (w_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_value <= i_data.value;
            r_quot  <= w_prod[RECIP_MOD_SH +: 3];
            r_en    <= i_data.digit_enable;
            r_dp    <= i_data.point_enable;
        end
    end

    // Remainder with one correction step
    assign w_rem     = 17'(r_value) - 17'(r_quot) * 17'(DISPLAY_MOD);
    assign w_rem_fix = (w_rem >= 17'(DISPLAY_MOD)) ? (w_rem - 17'(DISPLAY_MOD)) : w_rem;

    assign o_link.valid            = r_valid;
    assign o_link.job.num          = w_rem_fix[NUM_W-1:0];
    assign o_link.job.digit_enable = r_en;
    assign o_link.job.point_enable = r_dp;

endmodule

`default_nettype wire

@@ src/ldce_queue.sv @@
// ----------------------------------------------------------------------------
// ldce_queue
// Short job queue that decouples the front from the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_display_command_encoder_top_assert.svh"

module ldce_queue
    import ldce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job_link i_link,
    output logic           o_full,
    output t_job_link      o_link,
    input  wire logic      i_pop
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic              w_push;

    assign o_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push = i_link.valid && !o_full;

    assign n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the incoming job
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_link.job;
        end
    end

    assign o_link.valid = (r_count != '0);
    assign o_link.job   = r_mem[r_rd_ptr];

    `LDCE_ASSERT(a_q_bound, r_count <= QCNT_W'(QUEUE_DEPTH), "job queue overfilled")
    `LDCE_ASSERT(a_q_pop_empty, i_pop |-> r_count != '0, "job queue popped while empty")

endmodule

`default_nettype wire

@@ src/ldce_back.sv @@
// ----------------------------------------------------------------------------
// ldce_back
// Byte sequencer: emits opcode, enable mask and segment bytes of each job.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_display_command_encoder_top_assert.svh"

module ldce_back
    import ldce_pkg::*;
#(
    parameter logic [7:0] LED_SET_OPCODE = LED_SET_OPCODE_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job_link i_link,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_data
);

    localparam logic [1:0] PH_OP  = 2'd0;
    localparam logic [1:0] PH_EN  = 2'd1;
    localparam logic [1:0] PH_DIG = 2'd2;

    logic                 r_busy;
    logic [1:0]           r_phase;
    logic [DIG_IDX_W-1:0] r_idx;
    logic [NUM_W-1:0]     r_num;
    logic [3:0]           r_en;
    logic [3:0]           r_dp;
    logic                 r_out_valid;
    t_out_word            r_out;

    logic [29:0]          w_prod;
    logic [10:0]          w_quot;
    logic [NUM_W-1:0]     w_rem;
    logic [7:0]           w_seg;
    logic [3:0]           w_en_sh;
    logic                 w_out_free;
    logic                 w_produce;
    logic                 w_step;
    logic                 w_emit;
    logic                 w_finish;
    t_out_word            w_word;

    // Peel the ones digit off the remaining number
    assign w_prod  = 30'(r_num) * 30'(RECIP_TEN);
    assign w_quot  = w_prod[RECIP_TEN_SH +: 11];
    assign w_rem   = r_num - {w_quot, 3'b000} - NUM_W'({w_quot, 1'b0});
    assign w_seg   = seg_code(w_rem[3:0]) | (r_dp[r_idx] ? POINT_BIT : 8'h00);
    assign w_en_sh = r_en >> r_idx;

    // Select the byte of the current phase
    always_comb begin
        w_word    = '0;
        w_produce = 1'b1;
        unique case (r_phase)
            PH_OP: begin
                w_word.tx_byte   = LED_SET_OPCODE;
                w_word.last_byte = 1'b0;
            end
            PH_EN: begin
                w_word.tx_byte   = {4'b0000, r_en};
                w_word.last_byte = (r_en == 4'b0000);
            end
            PH_DIG: begin
                w_word.tx_byte   = w_seg;
                w_word.last_byte = (w_en_sh[3:1] == 3'b000);
                w_produce        = w_en_sh[0];
            end
            default: begin
                w_produce = 1'b0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_step     = r_busy && (w_out_free || !w_produce);
    assign w_emit     = w_step && w_produce;
    assign w_finish   = w_emit && w_word.last_byte;
    assign o_pop      = i_link.valid && (!r_busy || w_finish);

    // Advance through the command, loading the next job on the last byte or while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_OP;
            r_idx   <= '0;
        end else if (o_pop) begin
            r_busy  <= 1'b1;
            r_phase <= PH_OP;
            r_idx   <= '0;
        end else if (w_finish) begin
            r_busy  <= 1'b0;
            r_phase <= PH_OP;
            r_idx   <= '0;
        end else if (w_step) begin
            unique case (r_phase)
                PH_OP:   r_phase <= PH_EN;
                PH_EN:   r_phase <= PH_DIG;
                PH_DIG:  r_idx   <= r_idx + 1'b1;
                default: r_phase <= PH_OP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_num <= i_link.job.num;
            r_en  <= i_link.job.digit_enable;
            r_dp  <= i_link.job.point_enable;
        end else if (w_step && r_phase == PH_DIG) begin
            r_num <= NUM_W'(w_quot);
        end
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `LDCE_ASSERT_ALWAYS(a_idle_phase, !r_busy |-> r_phase == PH_OP, "idle sequencer out of phase")
    `LDCE_ASSERT(a_idx_phase, r_phase != PH_DIG |-> r_idx == '0, "digit index moved early")
    `LDCE_ASSERT(a_pop_load, o_pop |=> r_busy && r_phase == PH_OP, "job pop did not load")

endmodule

`default_nettype wire

@@ src/led_display_command_encoder_top.sv @@
// ----------------------------------------------------------------------------
// led_display_command_encoder_top
// Seven-segment display command encoder.
// ----------------------------------------------------------------------------
// Each accepted word (value, digit_enable, point_enable) becomes one display
// command of 2 to 6 output words: the opcode, the enable mask, then the
// segment byte of each enabled digit, ones digit first, with last_byte set on
// the final word. Only value modulo 10000 is shown. The byte sequencer steps
// through the opcode, the enable mask and each digit position up to the
// highest enabled one, passing disabled digits below it without output, and
// holds while the output register is stalled. A two-entry job queue and a
// one-word output register let new words be taken while earlier commands are
// still being sent; on its way out a word passes the front register, the job
// queue, the sequencer registers and the output register.
`default_nettype none

module led_display_command_encoder_top
    import ldce_pkg::*;
#(
    parameter logic [7:0] LED_SET_OPCODE = LED_SET_OPCODE_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_word  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_data
);

    t_job_link w_front_link;
    t_job_link w_queue_link;
    logic      w_queue_full;
    logic      w_pop;

    // Accept words and reduce the value
    ldce_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_link  (w_front_link),
        .i_full  (w_queue_full)
    );

    // Buffer classified jobs
    ldce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_front_link),
        .o_full  (w_queue_full),
        .o_link  (w_queue_link),
        .i_pop   (w_pop)
    );

    // Send command bytes
    ldce_back #(
        .LED_SET_OPCODE (LED_SET_OPCODE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_queue_link),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire
